[hw/rtl/tee_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tee_pkg;

	// fixed field geometry
	localparam int CHANNELS    = 12;
	localparam int CH_W        = 4;
	localparam int STATUS_W    = 12;
	localparam int KEY_W       = 8;
	localparam int COUNT_OUT_W = 5;
	localparam int MAP_ENTRIES = 20;
	localparam int MAP_W       = MAP_ENTRIES * KEY_W;
	localparam int WIN_W       = CHANNELS * KEY_W;
	localparam int IN_TDATA_W  = 16;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 16;
	localparam int OUT_TUSER_W = 1;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;

	localparam logic [KEY_W-1:0] UNMAPPED = 8'hFF;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MAP_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MAP_MID  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_MAP_HIGH = 2'd2;

	// item kinds
	localparam logic MODE_SCAN = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} tee_state_t;

	// queued event, released flag on top as in the store layout
	typedef struct packed {
		logic             released;
		logic [KEY_W-1:0] key;
	} tee_event_t;

	typedef struct packed {
		logic push;
		logic pop;
	} tee_ring_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/tee_event_ring.sv]
`timescale 1ns / 1ps
`default_nettype none

module tee_event_ring
	import tee_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire tee_ring_ctrl_t                   ctrl,
	input  wire tee_event_t                       push_event,
	output      tee_event_t                       head_event,
	output      logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

	tee_event_t       mem [QUEUE_DEPTH];
	tee_event_t       head_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] wr_next;
	logic [PTR_W-1:0] rd_next;

	assign wr_next = (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_next = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PTR_W'(1);

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem[wr_ptr_q] <= push_event;
		end
		head_q <= mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else if (ctrl.push) begin
			wr_ptr_q <= wr_next;
			// full: oldest word is dropped, count holds
			if (count_q == FULL_CNT) begin
				rd_ptr_q <= rd_next;
			end else begin
				count_q <= count_q + CNT_W'(1);
			end
		end else if (ctrl.pop && (count_q != '0)) begin
			rd_ptr_q <= rd_next;
			count_q  <= count_q - CNT_W'(1);
		end
	end

	assign head_event = head_q;
	assign count      = count_q;

endmodule

`default_nettype wire

[hw/rtl/touch_edge_event_queue.sv]
// Scan word: accepted, then the 12 channels are walked one channel bit per cycle, then a
//   finish step loads the result register once the result slot is free; the next word
//   is taken in the cycle after that load. Pop: accepted, then the finish step loads the
//   result. A new word is taken only in idle. The channel walk makes a scan longer than a pop.
// Reset (arst_n low, asynchronous): previous words, pointers and count cleared, key maps
//   all 0xFF (unmapped), no result pending. The event store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module touch_edge_event_queue
	import tee_pkg::*;
#(
	parameter int QUEUE_DEPTH       = 16,
	parameter int SECOND_MAP_OFFSET = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// config write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	// input words
	input  wire logic                   s_tvalid,
	output      logic                   s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [11:0] touch_status
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,   // [0] mode, [1] sensor_select
	// result words
	output      logic                   m_tvalid,
	input  wire logic                   m_tready,
	output      logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] event_key, [8] event_released,
	                                               // [13:9] pending_count
	output      logic [OUT_TUSER_W-1:0] m_tuser    // [0] event_valid
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CH_W-1:0] LAST_CH = CH_W'(CHANNELS - 1);

	// key map registers
	logic [63:0]          key_map_low_q;
	logic [63:0]          key_map_mid_q;
	logic [31:0]          key_map_high_q;
	logic [MAP_W-1:0]     map_vec;
	logic [WIN_W-1:0]     win_a;
	logic [WIN_W-1:0]     win_b;

	// per-sensor history
	logic [STATUS_W-1:0]  prev_a_q;
	logic [STATUS_W-1:0]  prev_b_q;

	// bit-serial walk: status, history and map bytes shift out together
	logic [STATUS_W-1:0]  cur_sh_q;
	logic [STATUS_W-1:0]  prev_sh_q;
	logic [WIN_W-1:0]     map_sh_q;
	logic [CH_W-1:0]      chan_q;
	logic                 mode_q;

	tee_state_t           state_q, state_d;
	tee_ring_ctrl_t       ring_ctrl;
	tee_event_t           push_evt;
	tee_event_t           head_evt;
	logic [CNT_W-1:0]     count;

	logic                 accept;
	logic                 out_load;
	logic                 ch_edge;
	logic                 pop_hit;

	// result register
	logic                   m_tvalid_q;
	logic [KEY_W-1:0]       out_key_q;
	logic                   out_rel_q;
	logic [COUNT_OUT_W-1:0] out_pend_q;
	logic                   out_valid_q;

	assign map_vec = {key_map_high_q, key_map_mid_q, key_map_low_q};
	assign win_a   = map_vec[WIN_W-1:0];
	assign win_b   = WIN_W'(map_vec >> (KEY_W * SECOND_MAP_OFFSET));

	assign accept  = s_tvalid && s_tready;
	// channel under the walk changed and has a key
	assign ch_edge = (cur_sh_q[0] != prev_sh_q[0]) && (map_sh_q[KEY_W-1:0] != UNMAPPED);
	assign pop_hit = (mode_q == MODE_POP) && (count != '0);

	assign push_evt.key      = map_sh_q[KEY_W-1:0];
	assign push_evt.released = prev_sh_q[0];

	// config writes; unlisted index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_map_low_q  <= '1;
			key_map_mid_q  <= '1;
			key_map_high_q <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEY_MAP_LOW:  key_map_low_q  <= cfg_wdata;
				REG_KEY_MAP_MID:  key_map_mid_q  <= cfg_wdata;
				REG_KEY_MAP_HIGH: key_map_high_q <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		ring_ctrl = '0;
		out_load  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser[0] == MODE_POP) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				ring_ctrl.push = ch_edge;
				if (chan_q == LAST_CH) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// wait for the result slot to free up
				if (!m_tvalid_q || m_tready) begin
					out_load      = 1'b1;
					ring_ctrl.pop = pop_hit;
					state_d       = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// history is written at accept; the old word is already in the shifter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_a_q <= '0;
			prev_b_q <= '0;
			chan_q   <= '0;
		end else if (accept) begin
			chan_q <= '0;
			if (s_tuser[0] == MODE_SCAN) begin
				if (s_tuser[1]) begin
					prev_b_q <= s_tdata[STATUS_W-1:0];
				end else begin
					prev_a_q <= s_tdata[STATUS_W-1:0];
				end
			end
		end else if (state_q == ST_SCAN) begin
			chan_q <= chan_q + CH_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q    <= s_tuser[0];
			cur_sh_q  <= s_tdata[STATUS_W-1:0];
			prev_sh_q <= s_tuser[1] ? prev_b_q : prev_a_q;
			map_sh_q  <= s_tuser[1] ? win_b : win_a;
		end else if (state_q == ST_SCAN) begin
			cur_sh_q  <= cur_sh_q >> 1;
			prev_sh_q <= prev_sh_q >> 1;
			map_sh_q  <= map_sh_q >> KEY_W;
		end
	end

	tee_event_ring #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ring_ctrl),
		.push_event (push_evt),
		.head_event (head_evt),
		.count      (count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// pending count is the count after this word; a hit pop leaves one less
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_valid_q <= pop_hit;
			out_key_q   <= pop_hit ? head_evt.key : '0;
			out_rel_q   <= pop_hit ? head_evt.released : 1'b0;
			if (pop_hit) begin
				out_pend_q <= COUNT_OUT_W'(count - CNT_W'(1));
			end else begin
				out_pend_q <= COUNT_OUT_W'(count);
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W - COUNT_OUT_W - 1 - KEY_W)'(0), out_pend_q, out_rel_q,
		out_key_q};
	assign m_tuser  = out_valid_q;

endmodule

`default_nettype wire

[hw/rtl/tee_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module tee_checker
	import tee_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic [OUT_TUSER_W-1:0] m_tuser
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// one word in flight: no accept right after an accept
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while previous word still at work");

	// no event means zero key and released
	a_empty_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> (m_tdata[7:0] == 8'd0) && !m_tdata[8])
		else $error("invalid event carries key data");

	// count never exceeds the queue depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[13:9]) <= 32'(QUEUE_DEPTH)))
		else $error("pending count beyond queue depth");

endmodule

bind touch_edge_event_queue tee_checker #(
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_tee_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire
